/* hdl/rbpc_pkg.sv */
// shared types, status codes and helpers for the level present counter
package rbpc_pkg;

  localparam int LEVEL_BITS_DEFAULT = 16;
  localparam int MAX_LEVEL_W        = 16;
  localparam int COUNT_W            = 31;
  localparam int STATUS_W           = 4;
  localparam int CFG_ADDR_W         = 1;
  localparam int CFG_DATA_W         = 31;
  localparam int HDR_W              = 32;
  localparam int RUN_LEFT_W         = 36;

  // register indexes on the config port
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_LEVEL    = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TOTAL_VALUES = 1'd1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK          = 4'd0;
  localparam logic [STATUS_W-1:0] ST_TRUNC_HDR   = 4'd1;
  localparam logic [STATUS_W-1:0] ST_HDR_LARGE   = 4'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_RLE_LEN = 4'd3;
  localparam logic [STATUS_W-1:0] ST_TRUNC_RLE   = 4'd4;
  localparam logic [STATUS_W-1:0] ST_LEVEL_LARGE = 4'd5;
  localparam logic [STATUS_W-1:0] ST_ZERO_GROUPS = 4'd6;
  localparam logic [STATUS_W-1:0] ST_TRUNC_PACK  = 4'd7;
  localparam logic [STATUS_W-1:0] ST_TRAILING    = 4'd8;

  typedef struct packed {
    logic [COUNT_W-1:0]  hit_count;
    logic [STATUS_W-1:0] status;
  } rbpc_result_t;

  // what one byte of a bit-packed run yields
  typedef struct packed {
    logic [MAX_LEVEL_W-1:0] acc;
    logic [3:0]             present_n;
    logic [3:0]             used_n;
    logic                   bad;
  } rbpc_unpack_t;

  // width of the level bit counter for a given level width cap
  function automatic int cnt_width(input int lb);
    int lw;
    lw = (lb < MAX_LEVEL_W) ? lb : MAX_LEVEL_W;
    return $clog2(lw + 1);
  endfunction

  // bits needed to hold max_level, at least one
  function automatic logic [4:0] level_width(input logic [MAX_LEVEL_W-1:0] v);
    logic [4:0] w;
    w = 5'd0;
    for (int i = 0; i < MAX_LEVEL_W; i++) begin
      if (v[i]) begin
        w = 5'(i + 1);
      end
    end
    if (w == 5'd0) begin
      w = 5'd1;
    end
    return w;
  endfunction

endpackage

/* hdl/rbpc_unpack.sv */
// splits one byte of a bit-packed run into levels, lsb first
module rbpc_unpack #(
  parameter int LEVEL_BITS = rbpc_pkg::LEVEL_BITS_DEFAULT,
  localparam int CntW = rbpc_pkg::cnt_width(LEVEL_BITS)
) (
  input  logic [7:0]                          byte_i,
  input  logic [rbpc_pkg::MAX_LEVEL_W-1:0]    acc_i,
  input  logic [CntW-1:0]                     bits_i,
  input  logic [CntW-1:0]                     w_i,
  input  logic [rbpc_pkg::MAX_LEVEL_W-1:0]    max_level_i,
  input  logic [rbpc_pkg::COUNT_W-1:0]        vals_left_i,
  output logic [CntW-1:0]                     bits_o,
  output rbpc_pkg::rbpc_unpack_t              res_o
);
  import rbpc_pkg::*;

  logic [MAX_LEVEL_W-1:0] acc;
  logic [CntW-1:0]        bits;
  logic [3:0]             pres;
  logic [3:0]             used;
  logic [3:0]             cap;
  logic                   bad;

  always_comb begin
    acc  = acc_i;
    bits = bits_i;
    pres = 4'd0;
    used = 4'd0;
    bad  = 1'b0;
    // levels past the values still missing are padding
    cap  = (vals_left_i >= 31'd8) ? 4'd8 : vals_left_i[3:0];
    for (int i = 0; i < 8; i++) begin
      acc  = acc | (MAX_LEVEL_W'(byte_i[i]) << bits);
      bits = bits + 1'b1;
      if (bits >= w_i) begin
        if (used < cap) begin
          if (acc > max_level_i) begin
            bad = 1'b1;
          end else if (acc == max_level_i) begin
            pres = pres + 4'd1;
          end
          used = used + 4'd1;
        end
        acc  = '0;
        bits = '0;
      end
    end
    bits_o          = bits;
    res_o.acc       = acc;
    res_o.present_n = pres;
    res_o.used_n    = used;
    res_o.bad       = bad;
  end

endmodule

/* hdl/rbpc_core.sv */
// decoder state, config registers and per-byte update of the hybrid stream
module rbpc_core #(
  parameter int LEVEL_BITS = rbpc_pkg::LEVEL_BITS_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rbpc_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [rbpc_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                              step_i,
  input  logic [7:0]                        byte_i,
  input  logic                              has_i,
  input  logic                              last_i,
  output rbpc_pkg::rbpc_result_t            result_o
);
  import rbpc_pkg::*;

  localparam int CntW = cnt_width(LEVEL_BITS);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_RLE    = 2'd1;
  localparam logic [1:0] PH_PACKED = 2'd2;

  // config
  logic [MAX_LEVEL_W-1:0] max_level_q;
  logic [COUNT_W-1:0]     total_q;
  logic [CntW-1:0]        w_q;
  logic [4:0]             w_raw;
  logic [CntW-1:0]        w_cap;

  // stream state
  logic [1:0]             phase_q, phase_d;
  logic [HDR_W-1:0]       hdr_acc_q, hdr_acc_d;
  logic [2:0]             hdr_cnt_q, hdr_cnt_d;
  logic [RUN_LEFT_W-1:0]  run_left_q, run_left_d;
  logic [COUNT_W-1:0]     run_len_q, run_len_d;
  logic [COUNT_W-1:0]     vals_left_q, vals_left_d;
  logic [MAX_LEVEL_W-1:0] lvl_acc_q, lvl_acc_d;
  logic                   lvl_hi_q, lvl_hi_d;
  logic [CntW-1:0]        lvl_bits_q, lvl_bits_d;
  logic [COUNT_W-1:0]     decoded_q, decoded_d;
  logic [COUNT_W-1:0]     present_q, present_d;
  logic [STATUS_W-1:0]    err_q, err_d;
  logic                   pend_q, pend_d;

  // combinational helpers
  logic [1:0]             nb;
  logic [4:0]             hdr_sh;
  logic [HDR_W-1:0]       hdr_new;
  logic [COUNT_W-1:0]     len;
  logic [COUNT_W-1:0]     remaining;
  logic [RUN_LEFT_W-1:0]  pack_bytes;
  logic [COUNT_W+2:0]     len8;
  logic [MAX_LEVEL_W-1:0] rle_lvl;
  logic                   rle_hi;
  logic                   add_en;
  logic [COUNT_W-1:0]     add_amt;
  logic [COUNT_W:0]       sat_sum;
  logic [COUNT_W-1:0]     present_sat;
  logic [CntW-1:0]        unp_bits;
  rbpc_unpack_t           unp;
  logic [STATUS_W-1:0]    fin_err;

  assign w_raw = level_width(cfg_wdata_i[MAX_LEVEL_W-1:0]);
  assign w_cap = (int'(w_raw) > LEVEL_BITS) ? CntW'(LEVEL_BITS) : CntW'(w_raw);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_level_q <= MAX_LEVEL_W'(1);
      total_q     <= '0;
      w_q         <= CntW'(1);
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_MAX_LEVEL: begin
          max_level_q <= cfg_wdata_i[MAX_LEVEL_W-1:0];
          w_q         <= w_cap;
        end
        REG_TOTAL_VALUES: begin
          total_q <= cfg_wdata_i;
        end
        default: begin
        end
      endcase
    end
  end

  rbpc_unpack #(
    .LEVEL_BITS (LEVEL_BITS)
  ) u_unpack (
    .byte_i      (byte_i),
    .acc_i       (lvl_acc_q),
    .bits_i      (lvl_bits_q),
    .w_i         (w_q),
    .max_level_i (max_level_q),
    .vals_left_i (vals_left_q),
    .bits_o      (unp_bits),
    .res_o       (unp)
  );

  // bytes per rle value
  assign nb = (5'(w_q) > 5'd8) ? 2'd2 : 2'd1;

  assign hdr_sh    = 5'(hdr_cnt_q) * 5'd7;
  assign hdr_new   = hdr_acc_q | (HDR_W'(byte_i[6:0]) << hdr_sh);
  assign len       = hdr_new[HDR_W-1:1];
  assign remaining = (decoded_q < total_q) ? (total_q - decoded_q) : '0;
  assign pack_bytes = RUN_LEFT_W'(len) * RUN_LEFT_W'(w_q);
  assign len8      = {len, 3'b000};

  // rle value bytes are little endian; a width change mid run can push a byte high
  always_comb begin
    rle_lvl = lvl_acc_q;
    rle_hi  = lvl_hi_q;
    if (run_left_q[1:0] == nb) begin
      rle_lvl = lvl_acc_q | MAX_LEVEL_W'(byte_i);
    end else if (nb == 2'd2) begin
      rle_lvl = lvl_acc_q | {byte_i, 8'h00};
    end else begin
      rle_hi = lvl_hi_q | (byte_i != 8'h00);
    end
  end

  assign sat_sum     = {1'b0, present_q} + (COUNT_W + 1)'(add_amt);
  assign present_sat = sat_sum[COUNT_W] ? '1 : sat_sum[COUNT_W-1:0];

  always_comb begin
    phase_d     = phase_q;
    hdr_acc_d   = hdr_acc_q;
    hdr_cnt_d   = hdr_cnt_q;
    run_left_d  = run_left_q;
    run_len_d   = run_len_q;
    vals_left_d = vals_left_q;
    lvl_acc_d   = lvl_acc_q;
    lvl_hi_d    = lvl_hi_q;
    lvl_bits_d  = lvl_bits_q;
    decoded_d   = decoded_q;
    present_d   = present_q;
    err_d       = err_q;
    pend_d      = pend_q;
    add_en      = 1'b0;
    add_amt     = '0;
    fin_err     = err_q;

    if (step_i && has_i && (err_q == ST_OK)) begin
      case (phase_q)
        PH_HEADER: begin
          if ((hdr_cnt_q == 3'd0) && (decoded_q >= total_q)) begin
            err_d = ST_TRAILING;
          end else if (byte_i[7]) begin
            hdr_acc_d = hdr_new;
            hdr_cnt_d = hdr_cnt_q + 3'd1;
            if (hdr_cnt_q == 3'd4) begin
              err_d = ST_HDR_LARGE;
            end
          end else begin
            hdr_acc_d  = '0;
            hdr_cnt_d  = '0;
            lvl_acc_d  = '0;
            lvl_hi_d   = 1'b0;
            lvl_bits_d = '0;
            if (!hdr_new[0]) begin
              if ((len == '0) || (len > remaining)) begin
                err_d = ST_BAD_RLE_LEN;
              end else begin
                run_len_d  = len;
                run_left_d = RUN_LEFT_W'(nb);
                phase_d    = PH_RLE;
              end
            end else begin
              if (len == '0) begin
                err_d = ST_ZERO_GROUPS;
              end else begin
                run_left_d  = pack_bytes;
                vals_left_d = ((COUNT_W + 3)'(remaining) < len8) ?
                              remaining : len8[COUNT_W-1:0];
                pend_d      = 1'b0;
                phase_d     = PH_PACKED;
              end
            end
          end
        end
        PH_RLE: begin
          lvl_acc_d  = rle_lvl;
          lvl_hi_d   = rle_hi;
          run_left_d = run_left_q - RUN_LEFT_W'(1);
          if (run_left_q == RUN_LEFT_W'(1)) begin
            if (rle_hi || (rle_lvl > max_level_q)) begin
              err_d = ST_LEVEL_LARGE;
            end else begin
              add_en    = (rle_lvl == max_level_q);
              add_amt   = run_len_q;
              decoded_d = decoded_q + run_len_q;
              lvl_acc_d = '0;
              lvl_hi_d  = 1'b0;
              phase_d   = PH_HEADER;
            end
          end
        end
        PH_PACKED: begin
          lvl_acc_d   = unp.acc;
          lvl_bits_d  = unp_bits;
          add_en      = 1'b1;
          add_amt     = COUNT_W'(unp.present_n);
          decoded_d   = decoded_q + COUNT_W'(unp.used_n);
          vals_left_d = vals_left_q - COUNT_W'(unp.used_n);
          pend_d      = pend_q | unp.bad;
          run_left_d  = run_left_q - RUN_LEFT_W'(1);
          if (run_left_q == RUN_LEFT_W'(1)) begin
            if (pend_q || unp.bad) begin
              err_d = ST_LEVEL_LARGE;
            end else begin
              lvl_acc_d  = '0;
              lvl_bits_d = '0;
              phase_d    = PH_HEADER;
            end
          end
        end
        default: begin
          phase_d = PH_HEADER;
        end
      endcase
    end

    if (add_en) begin
      present_d = present_sat;
    end

    // end of page: close out open runs, then start over
    fin_err = err_d;
    if (err_d == ST_OK) begin
      case (phase_d)
        PH_HEADER: begin
          if ((hdr_cnt_d != 3'd0) || (decoded_d < total_q)) begin
            fin_err = ST_TRUNC_HDR;
          end
        end
        PH_RLE: begin
          fin_err = ST_TRUNC_RLE;
        end
        PH_PACKED: begin
          fin_err = ST_TRUNC_PACK;
        end
        default: begin
        end
      endcase
    end

    result_o.status    = fin_err;
    result_o.hit_count = (fin_err == ST_OK) ? present_d : '0;

    if (step_i && last_i) begin
      phase_d     = PH_HEADER;
      hdr_acc_d   = '0;
      hdr_cnt_d   = '0;
      run_left_d  = '0;
      run_len_d   = '0;
      vals_left_d = '0;
      lvl_acc_d   = '0;
      lvl_hi_d    = 1'b0;
      lvl_bits_d  = '0;
      decoded_d   = '0;
      present_d   = '0;
      err_d       = ST_OK;
      pend_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      hdr_acc_q   <= '0;
      hdr_cnt_q   <= '0;
      run_left_q  <= '0;
      run_len_q   <= '0;
      vals_left_q <= '0;
      lvl_acc_q   <= '0;
      lvl_hi_q    <= 1'b0;
      lvl_bits_q  <= '0;
      decoded_q   <= '0;
      present_q   <= '0;
      err_q       <= ST_OK;
      pend_q      <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      hdr_acc_q   <= hdr_acc_d;
      hdr_cnt_q   <= hdr_cnt_d;
      run_left_q  <= run_left_d;
      run_len_q   <= run_len_d;
      vals_left_q <= vals_left_d;
      lvl_acc_q   <= lvl_acc_d;
      lvl_hi_q    <= lvl_hi_d;
      lvl_bits_q  <= lvl_bits_d;
      decoded_q   <= decoded_d;
      present_q   <= present_d;
      err_q       <= err_d;
      pend_q      <= pend_d;
    end
  end

endmodule

/* hdl/rle_bitpack_level_present_counter.sv */
// a result enters the output register as its last byte leaves the input register
// throughput: one payload byte per cycle while no last byte stalls; each byte passes
//   the input register, then the decode logic updates the stream state
// the input register keeps taking bytes while a result waits; only a last byte stalls
// reset is asynchronous: max_level returns to 1, total_values to 0, stream state clears
module rle_bitpack_level_present_counter #(
  parameter int LEVEL_BITS = rbpc_pkg::LEVEL_BITS_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rbpc_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [rbpc_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // data_byte
  input  logic                              s_axis_tuser,  // has_byte
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [39:0]                       m_axis_tdata   // hit_count, status, zero pad
);
  import rbpc_pkg::*;

  logic         stg_valid_q, stg_valid_d;
  logic [7:0]   stg_byte_q;
  logic         stg_has_q;
  logic         stg_last_q;
  logic         stg_adv;
  logic         out_free;
  logic         s_fire;
  logic         out_valid_q, out_valid_d;
  rbpc_result_t out_q;
  rbpc_result_t core_res;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign stg_adv       = stg_valid_q && (!stg_last_q || out_free);
  assign s_axis_tready = !stg_valid_q || stg_adv;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign stg_valid_d   = s_fire || (stg_valid_q && !stg_adv);
  assign out_valid_d   = (stg_adv && stg_last_q) || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      stg_valid_q <= stg_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      stg_byte_q <= s_axis_tdata;
      stg_has_q  <= s_axis_tuser;
      stg_last_q <= s_axis_tlast;
    end
    if (stg_adv && stg_last_q) begin
      out_q <= core_res;
    end
  end

  rbpc_core #(
    .LEVEL_BITS (LEVEL_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (stg_adv),
    .byte_i      (stg_byte_q),
    .has_i       (stg_has_q),
    .last_i      (stg_last_q),
    .result_o    (core_res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b00000, out_q.status, out_q.hit_count};

`ifndef SYNTH
  a_err_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.status != ST_OK)) |-> (out_q.hit_count == '0))
    else $error("nonzero count reported with an error status");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.status <= ST_TRAILING))
    else $error("status code out of range");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (stg_valid_q && stg_last_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without a blocked result");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stg_adv && stg_last_q) |=> out_valid_q)
    else $error("end of page did not produce a result");
`endif

endmodule
